[sv/srpc_pkg.sv]
`timescale 1ns / 1ps
package srpc_pkg;

    localparam logic [1:0] OP_ADD        = 2'd0;
    localparam logic [1:0] OP_CLOSE      = 2'd1;
    localparam logic [1:0] OP_MERGE_DONE = 2'd2;

    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_LATE = 2'd1;
    localparam logic [1:0] STS_BUSY = 2'd2;
    localparam logic [1:0] STS_FULL = 2'd3;

    localparam logic [31:0] WINDOW_RESET = 32'd1000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] timestamp;
        logic [31:0] sub_key;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  run_index;
        logic        new_run;
        logic        checkpoint_taken;
        logic [63:0] split_timestamp;
    } t_out_word;

    typedef struct packed {
        logic [63:0] top_time;
        logic [31:0] top_param;
    } t_run_top;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIVIDE,
        S_SEARCH,
        S_EVAL,
        S_FOUND,
        S_OUT
    } t_state;

endpackage

[sv/sorted_run_placement_checkpoint.sv]
`timescale 1ns / 1ps
// Sequencing: close, merge done and late adds go from S_CHECK straight to S_OUT for the result word.
// Adds at or past the newest timestamp pass through the one-bit-per-cycle 64-bit divider
// and then the binary searches over the run-top memory, each probe being a read in S_SEARCH
// and a compare in S_EVAL; older in-window adds skip the divider.
// Flow: one word at a time; the next word is taken once the result is accepted.
// Reset: synchronous, clears control state; run-top memory is left unwritten, no sweep.
module sorted_run_placement_checkpoint import srpc_pkg::*; #(
    parameter int MAX_RUNS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int CW = $clog2(MAX_RUNS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RUNS);

    t_run_top mem [MAX_RUNS];
    t_run_top r_rd;

    t_state    r_state, n_state;
    t_in_word  r_item, n_item;
    t_out_word r_res, n_res;
    logic [CW-1:0] r_count, n_count;
    logic [63:0]   r_newest, n_newest;
    logic [31:0]   r_ckpt, n_ckpt;
    logic          r_busy, n_busy;
    logic [31:0]   r_window;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [AW-1:0] r_mid, n_mid;
    logic          r_place, n_place;
    logic [63:0]   r_bound;

    logic          div_start, div_done;
    logic [63:0]   div_q;
    logic [31:0]   point;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic          pred;
    logic          mem_re, mem_we;
    logic [AW-1:0] mem_ra, mem_wa;
    t_run_top      mem_wd;

    srpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_item.timestamp),
        .i_divisor  (r_window),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign point   = (r_window == 32'd0) ? 32'hFFFF_FFFF : div_q[31:0];

    always_comb begin
        if (r_place) begin
            pred = !((r_item.timestamp < r_rd.top_time) ||
                     ((r_item.timestamp == r_rd.top_time) &&
                      (r_item.sub_key < r_rd.top_param)));
        end else begin
            pred = (r_rd.top_time < r_res.split_timestamp) ||
                   ((r_rd.top_time == r_res.split_timestamp) &&
                    (r_rd.top_param != 32'hFFFF_FFFF));
        end
    end

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_res     = r_res;
        n_count   = r_count;
        n_newest  = r_newest;
        n_ckpt    = r_ckpt;
        n_busy    = r_busy;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_place   = r_place;
        div_start = 1'b0;
        mem_re    = 1'b0;
        mem_ra    = mid[AW-1:0];
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = {r_item.timestamp, r_item.sub_key};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_word;
                    n_res   = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_OUT;
                case (r_item.opcode)
                    OP_CLOSE: begin
                        if (r_busy) begin
                            n_res.status = STS_BUSY;
                        end else begin
                            n_count = '0;
                            n_busy  = 1'b1;
                            n_res.checkpoint_taken = 1'b1;
                        end
                    end
                    OP_MERGE_DONE: begin
                        n_busy = 1'b0;
                    end
                    OP_ADD: begin
                        if (r_item.timestamp < r_newest) begin
                            if ((r_newest - r_item.timestamp) > {32'd0, r_window}) begin
                                n_res.status = STS_LATE;
                            end else begin
                                n_place = 1'b1;
                                n_lo    = '0;
                                n_hi    = r_count;
                                n_state = S_SEARCH;
                            end
                        end else begin
                            n_newest  = r_item.timestamp;
                            div_start = 1'b1;
                            n_state   = S_DIVIDE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DIVIDE: begin
                if (div_done) begin
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = S_SEARCH;
                    n_place = 1'b1;
                    if (point > r_ckpt) begin
                        if (r_busy) begin
                            n_res.status = STS_BUSY;
                            n_state      = S_OUT;
                        end else begin
                            n_busy  = 1'b1;
                            n_ckpt  = point;
                            n_place = 1'b0;
                            n_res.checkpoint_taken = 1'b1;
                            n_res.split_timestamp  = r_bound;
                        end
                    end
                end
            end
            S_SEARCH: begin
                if (r_lo < r_hi) begin
                    mem_re  = 1'b1;
                    n_mid   = mid[AW-1:0];
                    n_state = S_EVAL;
                end else begin
                    n_state = S_FOUND;
                end
            end
            S_EVAL: begin
                if (pred) begin
                    n_hi = CW'(r_mid);
                end else begin
                    n_lo = CW'(r_mid) + CW'(1);
                end
                n_state = S_SEARCH;
            end
            S_FOUND: begin
                if (!r_place) begin
                    n_count = r_lo;
                    n_lo    = '0;
                    n_hi    = r_lo;
                    n_place = 1'b1;
                    n_state = S_SEARCH;
                end else begin
                    n_state = S_OUT;
                    if (r_lo < r_count) begin
                        mem_we = 1'b1;
                        mem_wa = r_lo[AW-1:0];
                        n_res.run_index = 6'(r_lo);
                    end else if (r_count < MAX_CNT) begin
                        mem_we = 1'b1;
                        mem_wa = r_count[AW-1:0];
                        n_res.run_index = 6'(r_count);
                        n_res.new_run   = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_res.status = STS_FULL;
                    end
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_newest <= '0;
            r_ckpt   <= '0;
            r_busy   <= 1'b0;
            r_window <= WINDOW_RESET;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_newest <= n_newest;
            r_ckpt   <= n_ckpt;
            r_busy   <= n_busy;
            if (i_cfg_valid) begin
                r_window <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_res   <= n_res;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_place <= n_place;
        r_bound <= {32'd0, r_ckpt} * {32'd0, r_window};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_word  = r_res;
    assign o_cfg_ready = 1'b1;

endmodule

[sv/srpc_div.sv]
`timescale 1ns / 1ps
module srpc_div import srpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);

    logic        r_run;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_div;

    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_sub;

    assign rem_sh  = {r_rem, r_quo[63]};
    assign ge      = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 6'd63;
            end else if (r_run) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_quo <= {r_quo[62:0], ge};
            r_rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
